// File: hw/rtl/sc2a_pkg.sv
package sc2a_pkg;

    localparam int CODE_W = 8;
    localparam int CHAR_W = 7;
    localparam int IDX_W  = 6;

    localparam logic [CODE_W-1:0] CODE_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] CODE_CAPS_MAKE    = 8'h3A;
    localparam logic [CODE_W-1:0] CODE_ENTER        = 8'h1C;
    localparam logic [CODE_W-1:0] CODE_SPACE        = 8'h39;

    // Key classes for make codes below 0x40
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SHIFT  = 2'd1;
    localparam logic [1:0] KIND_LETTER = 2'd2;
    localparam logic [1:0] KIND_FIXED  = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] scan_code;
        logic              listener_present;
    } scan_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
    } char_item_t;

    typedef struct packed {
        logic left_shift_down;
        logic right_shift_down;
        logic caps_lock_on;
    } sc2a_mods_t;

    function automatic logic [1:0] kind_of(input logic [IDX_W-1:0] idx);
        logic [1:0] k;
        unique case (idx) inside
            [6'h02:6'h0B], [6'h33:6'h35]:             k = KIND_SHIFT;
            [6'h10:6'h19], [6'h1E:6'h26], [6'h2C:6'h32]: k = KIND_LETTER;
            CODE_ENTER[IDX_W-1:0], CODE_SPACE[IDX_W-1:0]: k = KIND_FIXED;
            default:                                   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_of(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            6'h02: c = 7'h31;
            6'h03: c = 7'h32;
            6'h04: c = 7'h33;
            6'h05: c = 7'h34;
            6'h06: c = 7'h35;
            6'h07: c = 7'h36;
            6'h08: c = 7'h37;
            6'h09: c = 7'h38;
            6'h0A: c = 7'h39;
            6'h0B: c = 7'h30;
            6'h10: c = 7'h71;
            6'h11: c = 7'h77;
            6'h12: c = 7'h65;
            6'h13: c = 7'h72;
            6'h14: c = 7'h74;
            6'h15: c = 7'h79;
            6'h16: c = 7'h75;
            6'h17: c = 7'h69;
            6'h18: c = 7'h6F;
            6'h19: c = 7'h70;
            6'h1C: c = 7'h0A;
            6'h1E: c = 7'h61;
            6'h1F: c = 7'h73;
            6'h20: c = 7'h64;
            6'h21: c = 7'h66;
            6'h22: c = 7'h67;
            6'h23: c = 7'h68;
            6'h24: c = 7'h6A;
            6'h25: c = 7'h6B;
            6'h26: c = 7'h6C;
            6'h2C: c = 7'h7A;
            6'h2D: c = 7'h78;
            6'h2E: c = 7'h63;
            6'h2F: c = 7'h76;
            6'h30: c = 7'h62;
            6'h31: c = 7'h6E;
            6'h32: c = 7'h6D;
            6'h33: c = 7'h2C;
            6'h34: c = 7'h2E;
            6'h35: c = 7'h2D;
            6'h39: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Shifted digits and punctuation; letters are uppercased separately
    function automatic logic [CHAR_W-1:0] shifted_of(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            6'h02: c = 7'h21;
            6'h03: c = 7'h27;
            6'h04: c = 7'h5E;
            6'h05: c = 7'h2B;
            6'h06: c = 7'h25;
            6'h07: c = 7'h26;
            6'h08: c = 7'h2F;
            6'h09: c = 7'h28;
            6'h0A: c = 7'h29;
            6'h0B: c = 7'h3D;
            6'h33: c = 7'h3B;
            6'h34: c = 7'h3A;
            6'h35: c = 7'h5F;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/sc2a_stream_if.sv
interface sc2a_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/scan_code_to_ascii_decoder_core.sv
// Scan code set 1 to ASCII decoder. Each transfer on scan_in carries one
// keyboard byte and a listener flag; each mapped make code seen while a listener
// is present yields one transfer on char_out holding its ASCII character. Shift
// make/break codes and the caps-lock make code update the modifier flags and
// produce no character; bytes without a listener are dropped with the flags
// untouched. The block accepts one byte per clock while char_out is not stalled:
// a byte goes from the input register through the key lookup into the output
// register, which drives char_out. Throughput is set by the output register
// alone: while char_out is stalled with a character pending, the input register
// fills and scan_in drops ready; otherwise ready stays high.
module scan_code_to_ascii_decoder_core
    import sc2a_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sc2a_stream_if.sink   scan_in,
    sc2a_stream_if.source char_out
);

    // Input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    scan_item_t        s1_item_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;

    logic              in_fire;
    logic              out_free;
    logic              s1_fire;
    logic              s1_live;
    sc2a_mods_t        mods;
    logic              map_hit;
    logic [CHAR_W-1:0] map_char;

    // Advance the input register whenever the output register is free or empties
    // this cycle; bytes that produce no character simply drop out.
    assign out_free      = ~out_valid_reg | char_out.ready;
    assign s1_fire       = s1_valid_reg & out_free;
    assign s1_live       = s1_fire & s1_item_reg.listener_present;
    assign scan_in.ready = ~s1_valid_reg | out_free;
    assign in_fire       = scan_in.valid & scan_in.ready;

    sc2a_shift_state u_shift_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (s1_live),
        .scan_code (s1_item_reg.scan_code),
        .mods      (mods)
    );

    // Lookup sees the flags as left by earlier bytes; updates land at the same edge
    sc2a_keymap u_keymap (
        .scan_code (s1_item_reg.scan_code),
        .mods      (mods),
        .hit       (map_hit),
        .char_code (map_char)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_live & map_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold unless a new transfer lands
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= scan_in.payload;
        end
        if (out_free)
        begin
            out_char_reg <= map_char;
        end
    end

    assign char_out.valid             = out_valid_reg;
    assign char_out.payload.char_code = out_char_reg;

    // A byte with no listener must never produce a character
    a_drop_no_listener: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_item_reg.listener_present) |=> !out_valid_reg)
        else $error("character produced for a byte without listener");

    // A mapped make code with a listener must show up at the output
    a_hit_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_live && map_hit) |=> out_valid_reg)
        else $error("mapped make code lost");

    // Caps-lock make code toggles the caps flag
    a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_live && s1_item_reg.scan_code == CODE_CAPS_MAKE)
            |=> (mods.caps_lock_on != $past(mods.caps_lock_on)))
        else $error("caps lock flag did not toggle");

    // Shift make codes never produce a character
    a_shift_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_live && (s1_item_reg.scan_code == CODE_LSHIFT_MAKE
                  || s1_item_reg.scan_code == CODE_RSHIFT_MAKE))
            |=> !out_valid_reg)
        else $error("shift make code produced a character");

endmodule

// File: hw/rtl/sc2a_shift_state.sv
module sc2a_shift_state
    import sc2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  logic [CODE_W-1:0] scan_code,
    output sc2a_mods_t        mods
);

    sc2a_mods_t mods_reg;
    sc2a_mods_t mods_next;

    always_comb
    begin
        mods_next = mods_reg;
        if (update)
        begin
            unique case (scan_code)
                CODE_LSHIFT_MAKE:  mods_next.left_shift_down  = 1'b1;
                CODE_LSHIFT_BREAK: mods_next.left_shift_down  = 1'b0;
                CODE_RSHIFT_MAKE:  mods_next.right_shift_down = 1'b1;
                CODE_RSHIFT_BREAK: mods_next.right_shift_down = 1'b0;
                CODE_CAPS_MAKE:    mods_next.caps_lock_on     = ~mods_reg.caps_lock_on;
                default:           mods_next = mods_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
        end
        else
        begin
            mods_reg <= mods_next;
        end
    end

    assign mods = mods_reg;

endmodule

// File: hw/rtl/sc2a_keymap.sv
module sc2a_keymap
    import sc2a_pkg::*;
(
    input  logic [CODE_W-1:0] scan_code,
    input  sc2a_mods_t        mods,
    output logic              hit,
    output logic [CHAR_W-1:0] char_code
);

    logic [IDX_W-1:0]  idx;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] plain_char;
    logic              shifted;

    assign idx        = scan_code[IDX_W-1:0];
    // Codes at 0x40 and up, break codes included, map to nothing
    assign kind       = (scan_code[CODE_W-1:IDX_W] != '0) ? KIND_NONE : kind_of(idx);
    assign plain_char = plain_of(idx);
    assign shifted    = mods.left_shift_down | mods.right_shift_down;
    assign hit        = (kind != KIND_NONE);

    always_comb
    begin
        unique case (kind)
            KIND_LETTER:
            begin
                // clear bit 5 to uppercase
                char_code = (shifted | mods.caps_lock_on)
                          ? {plain_char[6], 1'b0, plain_char[4:0]} : plain_char;
            end
            KIND_SHIFT: char_code = shifted ? shifted_of(idx) : plain_char;
            KIND_FIXED: char_code = plain_char;
            default:    char_code = '0;
        endcase
    end

endmodule
